// File: hdl/wialu_pkg.sv
// ----------------------------------------------------------------------------
// wialu_pkg - shared definitions for the 128-bit integer ALU
// Command codes, operand widths and the lane leading-zero helper.
// ----------------------------------------------------------------------------
package wialu_pkg;

    localparam int unsigned OP_W    = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned LANE_W  = 32;
    localparam int unsigned LANES   = OP_W / LANE_W;
    localparam int unsigned SHAMT_W = 7;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned LZ_W    = 8;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLZ = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd6;

    typedef logic [5:0] t_lane_lz;

    // Binary search over a 32-bit lane: five halving steps.
    function automatic t_lane_lz clz32(input logic [LANE_W-1:0] x);
        logic [LANE_W-1:0] v;
        t_lane_lz          n;
        v = x;
        n = '0;
        if (x == '0) begin
            return 6'd32;
        end
        if (v[31:16] == '0) begin
            n = n + 6'd16;
            v = v << 16;
        end
        if (v[31:24] == '0) begin
            n = n + 6'd8;
            v = v << 8;
        end
        if (v[31:28] == '0) begin
            n = n + 6'd4;
            v = v << 4;
        end
        if (v[31:30] == '0) begin
            n = n + 6'd2;
            v = v << 2;
        end
        if (!v[31]) begin
            n = n + 6'd1;
        end
        return n;
    endfunction

endpackage

// File: hdl/wide_integer_alu_128.sv
// ----------------------------------------------------------------------------
// wide_integer_alu_128 - pipelined 128-bit integer ALU with 256-bit multiply
// Add, subtract, logical shifts, unsigned compare, leading-zero count and a
// full 128x128 multiply built from 32x32 partial products and an adder tree.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_command, i_a_*, i_b_*, i_shift_amount
//  result    out        o_valid / i_stall    o_word0..3, o_carry_out, o_ge_flag,
//                                            o_leading_zeros
//
//  One request is taken every cycle while o_stall is low. The depth is
//  set by the multiply: operand register, 32x32 partial products, then three
//  adder-tree levels (row, half, full 256-bit sum).
//  Reset clears only the stage valid bits.
//  Stall ripples back stage by stage; empty stages keep filling while the
//  result side holds.
// ----------------------------------------------------------------------------
module wide_integer_alu_128
    import wialu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [HALF_W-1:0]  i_a_high,
    input  logic [HALF_W-1:0]  i_a_low,
    input  logic [HALF_W-1:0]  i_b_high,
    input  logic [HALF_W-1:0]  i_b_low,
    input  logic [SHAMT_W-1:0] i_shift_amount,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [HALF_W-1:0]  o_word0,
    output logic [HALF_W-1:0]  o_word1,
    output logic [HALF_W-1:0]  o_word2,
    output logic [HALF_W-1:0]  o_word3,
    output logic               o_carry_out,
    output logic               o_ge_flag,
    output logic [LZ_W-1:0]    o_leading_zeros
);

    localparam int unsigned NPP   = LANES * LANES;
    localparam int unsigned ROW_W = OP_W + LANE_W;
    localparam int unsigned HLF_W = OP_W + HALF_W;
    localparam int unsigned PRD_W = 2 * OP_W;

    // stage enables
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;

    // stage 1: operands
    logic [CMD_W-1:0]   r1_cmd;
    logic [OP_W-1:0]    r1_a, r1_b;
    logic [SHAMT_W-1:0] r1_sh;

    // stage 2: simple results, lane counts, partial products
    logic [CMD_W-1:0]    r2_cmd;
    logic [OP_W-1:0]     r2_res, n2_res;
    logic                r2_carry, n2_carry;
    logic                r2_ge, n2_ge;
    t_lane_lz            r2_lz [LANES];
    t_lane_lz            n2_lz [LANES];
    logic [2*LANE_W-1:0] r2_pp [NPP];
    logic [2*LANE_W-1:0] n2_pp [NPP];
    logic [OP_W:0]       n2_sum;

    // stage 3: row sums, final lz
    logic [CMD_W-1:0] r3_cmd;
    logic [OP_W-1:0]  r3_res;
    logic             r3_carry, r3_ge;
    logic [LZ_W-1:0]  r3_lz, n3_lz;
    logic [ROW_W-1:0] r3_row [LANES];
    logic [ROW_W-1:0] n3_row [LANES];

    // stage 4: half sums
    logic [CMD_W-1:0] r4_cmd;
    logic [OP_W-1:0]  r4_res;
    logic             r4_carry, r4_ge;
    logic [LZ_W-1:0]  r4_lz;
    logic [HLF_W-1:0] r4_half [2];
    logic [HLF_W-1:0] n4_half [2];

    // stage 5: output
    logic [CMD_W-1:0] r5_cmd;
    logic [PRD_W-1:0] r5_word, n5_word, n5_prod;
    logic             r5_carry, r5_ge;
    logic [LZ_W-1:0]  r5_lz;

    assign w_en5   = !r_vld5 || !i_stall;
    assign w_en4   = !r_vld4 || w_en5;
    assign w_en3   = !r_vld3 || w_en4;
    assign w_en2   = !r_vld2 || w_en3;
    assign w_en1   = !r_vld1 || w_en2;
    assign o_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (w_en1) r_vld1 <= i_valid;
            if (w_en2) r_vld2 <= r_vld1;
            if (w_en3) r_vld3 <= r_vld2;
            if (w_en4) r_vld4 <= r_vld3;
            if (w_en5) r_vld5 <= r_vld4;
        end
    end

    // ---- stage 2 logic
    always_comb begin
        n2_sum   = {1'b0, r1_a} + {1'b0, r1_b};
        n2_res   = '0;
        n2_carry = 1'b0;
        n2_ge    = 1'b0;
        case (r1_cmd)
            CMD_ADD: begin
                n2_res   = n2_sum[OP_W-1:0];
                n2_carry = n2_sum[OP_W];
            end
            CMD_SUB: n2_res = r1_a - r1_b;
            CMD_SHL: n2_res = r1_a << r1_sh;
            CMD_SHR: n2_res = r1_a >> r1_sh;
            CMD_GE:  n2_ge  = (r1_a >= r1_b);
            default: ;
        endcase
        for (int k = 0; k < LANES; k++) begin
            n2_lz[k] = clz32(r1_a[k*LANE_W +: LANE_W]);
        end
        for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < LANES; j++) begin
                n2_pp[i*LANES+j] = {{LANE_W{1'b0}}, r1_a[i*LANE_W +: LANE_W]}
                                 * {{LANE_W{1'b0}}, r1_b[j*LANE_W +: LANE_W]};
            end
        end
    end

    // ---- stage 3 logic: each row is a[i]*B, even and odd products interleaved
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n3_row[i] = {{LANE_W{1'b0}}, r2_pp[i*LANES+2], r2_pp[i*LANES+0]}
                      + {r2_pp[i*LANES+3], r2_pp[i*LANES+1], {LANE_W{1'b0}}};
        end
        n3_lz = '0;
        if (r2_cmd == CMD_CLZ) begin
            if (r2_lz[3] != 6'd32) begin
                n3_lz = {2'b0, r2_lz[3]};
            end else if (r2_lz[2] != 6'd32) begin
                n3_lz = 8'd32 + {2'b0, r2_lz[2]};
            end else if (r2_lz[1] != 6'd32) begin
                n3_lz = 8'd64 + {2'b0, r2_lz[1]};
            end else begin
                n3_lz = 8'd96 + {2'b0, r2_lz[0]};
            end
        end
    end

    // ---- stage 4 logic
    always_comb begin
        n4_half[0] = {{LANE_W{1'b0}}, r3_row[0]} + {r3_row[1], {LANE_W{1'b0}}};
        n4_half[1] = {{LANE_W{1'b0}}, r3_row[2]} + {r3_row[3], {LANE_W{1'b0}}};
    end

    // ---- stage 5 logic
    always_comb begin
        n5_prod = {{HALF_W{1'b0}}, r4_half[0]} + {r4_half[1], {HALF_W{1'b0}}};
        if (r4_cmd == CMD_MUL) begin
            n5_word = n5_prod;
        end else begin
            n5_word = {{OP_W{1'b0}}, r4_res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_cmd <= i_command;
            r1_a   <= {i_a_high, i_a_low};
            r1_b   <= {i_b_high, i_b_low};
            r1_sh  <= i_shift_amount;
        end
        if (w_en2) begin
            r2_cmd   <= r1_cmd;
            r2_res   <= n2_res;
            r2_carry <= n2_carry;
            r2_ge    <= n2_ge;
            r2_lz    <= n2_lz;
            r2_pp    <= n2_pp;
        end
        if (w_en3) begin
            r3_cmd   <= r2_cmd;
            r3_res   <= r2_res;
            r3_carry <= r2_carry;
            r3_ge    <= r2_ge;
            r3_lz    <= n3_lz;
            r3_row   <= n3_row;
        end
        if (w_en4) begin
            r4_cmd   <= r3_cmd;
            r4_res   <= r3_res;
            r4_carry <= r3_carry;
            r4_ge    <= r3_ge;
            r4_lz    <= r3_lz;
            r4_half  <= n4_half;
        end
        if (w_en5) begin
            r5_cmd   <= r4_cmd;
            r5_word  <= n5_word;
            r5_carry <= r4_carry;
            r5_ge    <= r4_ge;
            r5_lz    <= r4_lz;
        end
    end

    assign o_valid         = r_vld5;
    assign o_word0         = r5_word[0*HALF_W +: HALF_W];
    assign o_word1         = r5_word[1*HALF_W +: HALF_W];
    assign o_word2         = r5_word[2*HALF_W +: HALF_W];
    assign o_word3         = r5_word[3*HALF_W +: HALF_W];
    assign o_carry_out     = r5_carry;
    assign o_ge_flag       = r5_ge;
    assign o_leading_zeros = r5_lz;

`ifndef SYNTH
    a_take_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld1)
        else $error("accepted request did not reach stage 1");

    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld5 && r5_cmd != CMD_MUL) |-> (o_word2 == '0 && o_word3 == '0))
        else $error("upper product words set on a non-multiply result");

    a_lz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld5 |-> (o_leading_zeros <= 8'd128 && !(o_carry_out && o_ge_flag)))
        else $error("leading-zero count or flags out of range");

    a_lz_only_clz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld5 && r5_cmd != CMD_CLZ) |-> (o_leading_zeros == '0))
        else $error("leading-zero count set on another command");
`endif

endmodule
